### rtl/fpgt_pkg.sv
package fpgt_pkg;

  // Field widths
  localparam int GAIN_W  = 32;
  localparam int DATA_W  = 32;
  localparam int SPAN_W  = 31;
  localparam int CFG_IDX_W = 3;

  // Divider sizing: widest numerator is |x| * 6 * 2^16, 32 by 20 bits
  localparam int NUM_W = 52;
  localparam int DEN_W = SPAN_W;
  localparam int CNT_W = $clog2(NUM_W);

  // Internal datapath widths
  localparam int Q_W     = 20;  // quantized value, Q.16 in [-6,6]
  localparam int W_W     = 18;  // membership weight, units 2^-17
  localparam int WP_W    = 35;  // product of two weights
  localparam int S_W     = 42;  // weighted rule sum
  localparam int QK_W    = 30;  // rule output, units 2^-24
  localparam int PROD_W  = 62;  // range * qk
  localparam int DELTA_W = 38;  // gain step
  localparam int ACC_W   = 39;  // gain + step before clamp

  // Scaling by 6 * 2^24: drop 25 bits, then divide by 3 by reciprocal
  localparam int MAG_W  = 33;  // |range * qk| >> 25, at most 3 * 2^31
  localparam int SCL_SH = 25;
  localparam int RCP_SH = 34;
  localparam logic [MAG_W-1:0] RCP3 = 33'h155555556;  // ceil(2^34 / 3)

  // Fixed-point constants
  localparam int UNI6       = 393216;     // 6.0 in Q.16
  localparam int ONE17      = 131072;     // one membership
  localparam int SCALE_ERR  = 393216;     // 6 * 2^16
  localparam int SCALE_RATE = 196608;     // 3 * 2^16
  localparam int DELTA_DIV  = 100663296;  // 6 * 2^24
  localparam logic [SPAN_W-1:0] SPAN_RESET = 31'd65536;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_RANGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_INIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_INIT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KD_INIT  = 3'd6;

  // Gain table selectors
  localparam logic [1:0] TB_KP = 2'd0;
  localparam logic [1:0] TB_KI = 2'd1;
  localparam logic [1:0] TB_KD = 2'd2;

  typedef enum logic {
    DIV_ERR,
    DIV_RATE
  } div_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch_in;
    logic       div_start;
    div_sel_e   div_sel;
    logic       store_qe;
    logic       store_qr;
    logic       fuzz;
    logic       prod_en;
    logic       sum_en;
    logic       mul_en;
    logic       scl_en;
    logic       rcp_en;
    logic       gain_upd;
    logic       out_load;
    logic [1:0] idx;
  } fpgt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
    logic span_zero;
    logic oor;
  } fpgt_sts_t;

  // Rule tables, rows by error cell, columns by rate cell
  localparam int RULE_KP [7][7] = '{
    '{6, 6, 4, 4, 2, 0, 0},
    '{6, 6, 4, 2, 2, 0, -2},
    '{4, 4, 4, 2, 0, -2, -2},
    '{4, 4, 2, 0, -2, -4, -4},
    '{2, 2, 0, -2, -2, -4, -4},
    '{2, 0, -2, -4, -4, -4, -6},
    '{0, 0, -4, -4, -4, -6, -6}};

  localparam int RULE_KI [7][7] = '{
    '{-6, -6, -4, -4, -2, 0, 0},
    '{-6, -6, -4, -2, -2, 0, 0},
    '{-6, -4, -2, -2, 0, 2, 2},
    '{-4, -4, -2, 0, 2, 4, 4},
    '{-4, -2, 0, 2, 2, 4, 6},
    '{0, 0, 2, 2, 4, 6, 6},
    '{0, 0, 2, 4, 4, 6, 6}};

  localparam int RULE_KD [7][7] = '{
    '{2, -2, -6, -6, -6, -4, 2},
    '{2, -2, -6, -4, -4, -2, 0},
    '{0, -2, -4, -4, -2, -2, 0},
    '{0, -2, -2, -2, -2, -2, 0},
    '{0, 0, 0, 0, 0, 0, 0},
    '{6, -2, 2, 2, 2, 2, 6},
    '{6, 4, 4, 4, 2, 2, 6}};

  function automatic logic signed [3:0] rule_at(input logic [1:0] tb,
                                                input logic [2:0] row,
                                                input logic [2:0] col);
    unique case (tb)
      TB_KP:   rule_at = 4'(RULE_KP[row][col]);
      TB_KI:   rule_at = 4'(RULE_KI[row][col]);
      default: rule_at = 4'(RULE_KD[row][col]);
    endcase
  endfunction

endpackage

### rtl/fuzzy_pid_gain_tuner.sv
// Fuzzy self-tuning PID gain tuner. Each input word (error, error rate, Q16.16)
// is quantized into [-6,6], weighted over four cells of the 7x7 Kp, Ki and Kd
// rule tables, scaled by the adjust ranges over 6 and added with saturation
// to the kept gains, which come out as one result word. The next word is
// taken only after the result is loaded. The work is done by one 52-step
// restoring divider used twice in turn for the two quantizations, then four
// weight products and, per gain, a sum, multiply, shift, reciprocal divide
// by 3 and update. An input outside the universe skips the weighting and
// leaves the gains as they are, and a zero error span also skips the
// divisions. A waiting output word that is not taken holds the next result
// back, and with it the next input. Configuration writes are always ready;
// writing an initial gain also loads the kept gain.
module fuzzy_pid_gain_tuner import fpgt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] error_i,
  input  logic signed [DATA_W-1:0] delta_error_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [GAIN_W-1:0] kp_out_o,
  output logic signed [GAIN_W-1:0] ki_out_o,
  output logic signed [GAIN_W-1:0] kd_out_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i
);

  fpgt_cmd_t cmd;
  fpgt_sts_t sts;

  assign cfg_ready_o = 1'b1;

  fpgt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fpgt_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .error_i       (error_i),
    .delta_error_i (delta_error_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kp_out_o      (kp_out_o),
    .ki_out_o      (ki_out_o),
    .kd_out_o      (kd_out_o)
  );

endmodule

### rtl/fpgt_div.sv
// Restoring divider, one quotient bit per cycle
module fpgt_div import fpgt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;

  // One shift-subtract step
  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[NUM_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(NUM_W - 1);
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (run_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = DEN_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/fpgt_dp.sv
// Datapath: config registers, gains, fuzzifier, rule weighting, scaling
module fpgt_dp import fpgt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fpgt_cmd_t                cmd_i,
  output fpgt_sts_t                sts_o,
  input  logic signed [DATA_W-1:0] error_i,
  input  logic signed [DATA_W-1:0] delta_error_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DATA_W-1:0]        cfg_data_i,
  output logic signed [GAIN_W-1:0] kp_out_o,
  output logic signed [GAIN_W-1:0] ki_out_o,
  output logic signed [GAIN_W-1:0] kd_out_o
);

  logic [SPAN_W-1:0]        span_q;
  logic signed [DATA_W-1:0] range_q [3];
  logic signed [GAIN_W-1:0] gain_q [3];
  logic signed [GAIN_W-1:0] out_q [3];

  logic signed [DATA_W-1:0] err_q, rate_q;
  logic signed [Q_W-1:0]    qe_q, qr_q;
  logic                     oore_q, oorr_q;
  logic [2:0]               se_q, sc_q;
  logic [W_W-1:0]           we_q [2];
  logic [W_W-1:0]           wc_q [2];
  logic [WP_W-1:0]          wprod_q [4];
  logic signed [QK_W-1:0]   qk_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     div_neg_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     scl_neg_q;
  logic [GAIN_W-1:0]        dq_q;

  // Divider operands
  logic [DATA_W-1:0]      abs_e, abs_r;
  logic [NUM_W-1:0]       mag_e, mag_r;
  logic [PROD_W-1:0]      prod_mag;
  logic [NUM_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den;
  logic                   div_neg;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quo;

  always_comb begin
    abs_e    = err_q[DATA_W-1] ? DATA_W'(-err_q) : DATA_W'(err_q);
    abs_r    = rate_q[DATA_W-1] ? DATA_W'(-rate_q) : DATA_W'(rate_q);
    mag_e    = abs_e * 20'(SCALE_ERR);
    mag_r    = abs_r * 20'(SCALE_RATE);
    prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    div_den  = span_q;
    case (cmd_i.div_sel)
      DIV_ERR: begin
        div_num = mag_e;
        div_neg = err_q[DATA_W-1];
      end
      default: begin
        div_num = mag_r;
        div_neg = rate_q[DATA_W-1];
      end
    endcase
  end

  fpgt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Quantized value from quotient, with universe check
  logic                  q_oor;
  logic signed [Q_W-1:0] q_val;

  always_comb begin
    q_oor = div_quo > NUM_W'(UNI6);
    q_val = div_neg_q ? Q_W'(-div_quo[Q_W-1:0]) : Q_W'(div_quo[Q_W-1:0]);
  end

  // Segment and weights for both quantized values
  logic [Q_W-1:0] ue, ur;
  logic [2:0]     se_d, sc_d;
  logic [W_W-1:0] te, tr;

  always_comb begin
    ue   = Q_W'(qe_q) + Q_W'(UNI6);
    ur   = Q_W'(qr_q) + Q_W'(UNI6);
    se_d = (ue[Q_W-1:17] > 3'd5) ? 3'd5 : ue[Q_W-1:17];
    sc_d = (ur[Q_W-1:17] > 3'd5) ? 3'd5 : ur[Q_W-1:17];
    te   = W_W'(ue - {se_d, 17'd0});
    tr   = W_W'(ur - {sc_d, 17'd0});
  end

  // Weight product for one of the four cells
  logic [2*W_W-1:0] wp_full;
  assign wp_full = we_q[cmd_i.idx[1]] * wc_q[cmd_i.idx[0]];

  // Weighted rule sum for the selected table, truncated to units 2^-24
  logic signed [S_W-1:0]  s_sum, s_term, s_adj;
  logic signed [3:0]      rule;
  logic [1:0]             cc;
  logic signed [QK_W-1:0] qk_d;

  always_comb begin
    s_sum = '0;
    for (int c = 0; c < 4; c++) begin
      cc     = 2'(c);
      rule   = rule_at(cmd_i.idx, se_q + {2'b0, cc[1]}, sc_q + {2'b0, cc[0]});
      s_term = $signed({1'b0, wprod_q[cc]}) * rule;
      s_sum  = s_sum + s_term;
    end
    s_adj = s_sum[S_W-1] ? s_sum + S_W'(1023) : s_sum;
    qk_d  = QK_W'(s_adj >>> 10);
  end

  // Divide by 3 of the shifted magnitude, by reciprocal
  logic [2*MAG_W-1:0] rcp_full;
  assign rcp_full = mag_q * RCP3;

  // Saturating gain update
  logic signed [DELTA_W-1:0] delta;
  logic signed [ACC_W-1:0]   acc;
  logic signed [GAIN_W-1:0]  gain_new;

  always_comb begin
    delta = scl_neg_q ? -$signed({{(DELTA_W-GAIN_W){1'b0}}, dq_q})
                      : $signed({{(DELTA_W-GAIN_W){1'b0}}, dq_q});
    acc   = ACC_W'(gain_q[cmd_i.idx]) + ACC_W'(delta);
    if (acc > $signed(ACC_W'({1'b0, {(GAIN_W-1){1'b1}}}))) begin
      gain_new = {1'b0, {(GAIN_W-1){1'b1}}};
    end else if (acc < -$signed(ACC_W'({1'b1, {(GAIN_W-1){1'b0}}}))) begin
      gain_new = {1'b1, {(GAIN_W-1){1'b0}}};
    end else begin
      gain_new = GAIN_W'(acc);
    end
  end

  // Config registers and kept gains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= SPAN_RESET;
      for (int i = 0; i < 3; i++) begin
        range_q[i] <= '0;
        gain_q[i]  <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SPAN:     span_q     <= cfg_data_i[SPAN_W-1:0];
        CFG_KP_RANGE: range_q[0] <= cfg_data_i;
        CFG_KI_RANGE: range_q[1] <= cfg_data_i;
        CFG_KD_RANGE: range_q[2] <= cfg_data_i;
        CFG_KP_INIT:  gain_q[0]  <= cfg_data_i;
        CFG_KI_INIT:  gain_q[1]  <= cfg_data_i;
        CFG_KD_INIT:  gain_q[2]  <= cfg_data_i;
        default: ;
      endcase
    end else if (cmd_i.gain_upd) begin
      gain_q[cmd_i.idx] <= gain_new;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      err_q  <= error_i;
      rate_q <= delta_error_i;
    end
    if (cmd_i.div_start) div_neg_q <= div_neg;
    if (cmd_i.store_qe) begin
      qe_q   <= q_val;
      oore_q <= q_oor;
    end
    if (cmd_i.store_qr) begin
      qr_q   <= q_val;
      oorr_q <= q_oor;
    end
    if (cmd_i.fuzz) begin
      se_q  <= se_d;
      sc_q  <= sc_d;
      we_q[0] <= W_W'(ONE17) - te;
      we_q[1] <= te;
      wc_q[0] <= W_W'(ONE17) - tr;
      wc_q[1] <= tr;
    end
    if (cmd_i.prod_en) wprod_q[cmd_i.idx] <= wp_full[WP_W-1:0];
    if (cmd_i.sum_en)  qk_q   <= qk_d;
    if (cmd_i.mul_en)  prod_q <= range_q[cmd_i.idx] * qk_q;
    if (cmd_i.scl_en) begin
      mag_q     <= prod_mag[SCL_SH+MAG_W-1:SCL_SH];
      scl_neg_q <= prod_q[PROD_W-1];
    end
    if (cmd_i.rcp_en)  dq_q   <= rcp_full[RCP_SH+GAIN_W-1:RCP_SH];
    if (cmd_i.out_load) begin
      for (int i = 0; i < 3; i++) out_q[i] <= gain_q[i];
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.span_zero = (span_q == '0);
  assign sts_o.oor       = oore_q | oorr_q;

  assign kp_out_o = out_q[0];
  assign ki_out_o = out_q[1];
  assign kd_out_o = out_q[2];

endmodule

### rtl/fpgt_ctrl.sv
// Sequencer for one tuning step
module fpgt_ctrl import fpgt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fpgt_cmd_t cmd_o,
  input  fpgt_sts_t sts_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVE  = 4'd1;
  localparam logic [3:0] S_WAITE = 4'd2;
  localparam logic [3:0] S_DIVR  = 4'd3;
  localparam logic [3:0] S_WAITR = 4'd4;
  localparam logic [3:0] S_FUZZ  = 4'd5;
  localparam logic [3:0] S_PROD  = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_SCL   = 4'd9;
  localparam logic [3:0] S_RCP   = 4'd10;
  localparam logic [3:0] S_UPD   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] tb_q, tb_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    tb_d    = tb_q;
    cmd_o   = '0;
    cmd_o.div_sel = DIV_ERR;
    cmd_o.idx     = tb_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DIVE;
        end
      end
      S_DIVE: begin
        if (sts_i.span_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_ERR;
          state_d = S_WAITE;
        end
      end
      S_WAITE: begin
        if (sts_i.div_done) begin
          cmd_o.store_qe = 1'b1;
          state_d = S_DIVR;
        end
      end
      S_DIVR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_RATE;
        state_d = S_WAITR;
      end
      S_WAITR: begin
        if (sts_i.div_done) begin
          cmd_o.store_qr = 1'b1;
          state_d = S_FUZZ;
        end
      end
      S_FUZZ: begin
        if (sts_i.oor) begin
          state_d = S_OUT;
        end else begin
          cmd_o.fuzz = 1'b1;
          cnt_d   = '0;
          state_d = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod_en = 1'b1;
        cmd_o.idx     = cnt_q;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 2'd3) begin
          tb_d    = TB_KP;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = S_SCL;
      end
      S_SCL: begin
        cmd_o.scl_en = 1'b1;
        state_d = S_RCP;
      end
      S_RCP: begin
        cmd_o.rcp_en = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.gain_upd = 1'b1;
        if (tb_q == TB_KD) begin
          state_d = S_OUT;
        end else begin
          tb_d    = tb_q + 1'b1;
          state_d = S_SUM;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output word valid: set on load, cleared once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      tb_q        <= TB_KP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tb_q        <= tb_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### tb/tb_top.sv
module tb_top;
  import fpgt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RAND_WORDS = 104;
  localparam int  PHASES     = 8;
  localparam int  DRAIN_CYC  = 400;
  localparam int  LIMIT_CYC  = 3000000;
  localparam int  MAX_REPORT = 10;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
  } gain_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] err;
    logic signed [DATA_W-1:0] rate;
    bit                       typed;
    gain_word_t               gains;
  } dir_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] error_i = '0;
  logic signed [DATA_W-1:0] delta_error_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [GAIN_W-1:0] kp_out_o;
  logic signed [GAIN_W-1:0] ki_out_o;
  logic signed [GAIN_W-1:0] kd_out_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = CFG_SPAN;
  logic [DATA_W-1:0]        cfg_data_i = '0;

  fuzzy_pid_gain_tuner dut (.*);

  always #1 clk_i = ~clk_i;

  // Tuner shadow state
  logic [SPAN_W-1:0] span_r;
  longint            kp_rng, ki_rng, kd_rng;
  longint            kp_g, ki_g, kd_g;

  gain_word_t pending_gains[$];
  int         mismatches = 0;
  int         cycles = 0;
  bit         calm = 1'b0;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Quantize into [-6,6] Q.16, return segment and the two weights
  function automatic bit fuzz_pos(input longint x, input longint k, output int seg,
                                  output longint w0, output longint w1);
    longint q, s, t;
    seg = 0; w0 = 0; w1 = 0;
    if (span_r == '0) return 1'b0;
    q = (x * k * 65536) / longint'(span_r);
    if (q < -UNI6 || q > UNI6) return 1'b0;
    s = (q + UNI6) / ONE17;
    if (s > 5) s = 5;
    t = q + UNI6 - s * ONE17;
    seg = int'(s);
    w0 = ONE17 - t;
    w1 = t;
    return 1'b1;
  endfunction

  function automatic longint gain_step(input logic [1:0] tsel, input int se,
                                       input longint we[2], input int sc,
                                       input longint wc[2], input longint rng);
    longint acc, qk;
    int     rv;
    acc = 0;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        case (tsel)
          TB_KP:   rv = RULE_KP[se+i][sc+j];
          TB_KI:   rv = RULE_KI[se+i][sc+j];
          default: rv = RULE_KD[se+i][sc+j];
        endcase
        acc += we[i] * wc[j] * longint'(rv);
      end
    qk = acc / 1024;
    return (rng * qk) / DELTA_DIV;
  endfunction

  // Advance the kept gains by one word
  function automatic gain_word_t tune_gains(input logic signed [DATA_W-1:0] e,
                                            input logic signed [DATA_W-1:0] r);
    int         se, sc;
    longint     we[2], wc[2];
    gain_word_t g;
    if (fuzz_pos(longint'(e), 6, se, we[0], we[1]) &&
        fuzz_pos(longint'(r), 3, sc, wc[0], wc[1])) begin
      kp_g = clamp32(kp_g + gain_step(TB_KP, se, we, sc, wc, kp_rng));
      ki_g = clamp32(ki_g + gain_step(TB_KI, se, we, sc, wc, ki_rng));
      kd_g = clamp32(kd_g + gain_step(TB_KD, se, we, sc, wc, kd_rng));
    end
    g.kp = kp_g[31:0];
    g.ki = ki_g[31:0];
    g.kd = kd_g[31:0];
    return g;
  endfunction

  task automatic send_word(input logic signed [DATA_W-1:0] e,
                           input logic signed [DATA_W-1:0] r,
                           input bit typed, input gain_word_t typed_gains);
    gain_word_t g;
    if (!calm)
      while ($urandom_range(0, 99) < 33) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i    <= 1'b1;
    error_i       <= e;
    delta_error_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    g = tune_gains(e, r);
    pending_gains.push_back(typed ? typed_gains : g);
  endtask

  // Valid is left high; the caller drops it after a batch
  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_SPAN:     span_r = data[SPAN_W-1:0];
      CFG_KP_RANGE: kp_rng = longint'($signed(data));
      CFG_KI_RANGE: ki_rng = longint'($signed(data));
      CFG_KD_RANGE: kd_rng = longint'($signed(data));
      CFG_KP_INIT:  kp_g   = longint'($signed(data));
      CFG_KI_INIT:  ki_g   = longint'($signed(data));
      CFG_KD_INIT:  kd_g   = longint'($signed(data));
      default: ;
    endcase
  endtask

  // Drain, then write every register
  task automatic load_config(input logic [DATA_W-1:0] span, input logic [DATA_W-1:0] kpr,
                             input logic [DATA_W-1:0] kir, input logic [DATA_W-1:0] kdr,
                             input logic [DATA_W-1:0] kpi, input logic [DATA_W-1:0] kii,
                             input logic [DATA_W-1:0] kdi);
    in_valid_i <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_put(CFG_SPAN, span);
    cfg_put(CFG_KP_RANGE, kpr);
    cfg_put(CFG_KI_RANGE, kir);
    cfg_put(CFG_KD_RANGE, kdr);
    cfg_put(CFG_KP_INIT, kpi);
    cfg_put(CFG_KI_INIT, kii);
    cfg_put(CFG_KD_INIT, kdi);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_range_word(input int mode);
    case (mode)
      0:       return DATA_W'($urandom_range(0, 20 * 65536));
      1:       return DATA_W'(-$signed($urandom_range(0, 20 * 65536)));
      default: return $urandom();
    endcase
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    gain_word_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_gains.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("unexpected word: kp %h ki %h kd %h", kp_out_o, ki_out_o, kd_out_o);
      end else begin
        want = pending_gains.pop_front();
        if (kp_out_o !== want.kp || ki_out_o !== want.ki || kd_out_o !== want.kd) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display("mismatch: kp %h/%h ki %h/%h kd %h/%h (exp/got)", want.kp, kp_out_o,
                     want.ki, ki_out_o, want.kd, kd_out_o);
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i)
    out_stall_i <= !calm && ($urandom_range(0, 99) < 33);

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYC) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  dir_row_t dir_rows[18];

  initial begin
    longint     sp, e, r;
    int         pick;
    gain_word_t none;
    none = '0;
    // Reset values: span one, no adjust, gains zero
    span_r = SPAN_RESET;
    kp_rng = 0; ki_rng = 0; kd_rng = 0;
    kp_g = 0; ki_g = 0; kd_g = 0;

    dir_rows = '{
      '{32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 32'sd0}},
      '{32'sh7fffffff, 32'sh80000000, 1'b1, '{32'sd0, 32'sd0, 32'sd0}},
      // with span 1.0, ranges 6.0, gains 1.0 / 2.0 / 3.0
      '{32'sd0, 32'sd0, 1'b1, '{32'sd65536, 32'sd131072, 32'sd65536}},
      '{32'sd65536, 32'sd131072, 1'b1, '{-32'sd327680, 32'sd524288, 32'sd458752}},
      '{-32'sd65536, -32'sd131072, 1'b1, '{32'sd65536, 32'sd131072, 32'sd589824}},
      '{32'sd65537, 32'sd0, 1'b1, '{32'sd65536, 32'sd131072, 32'sd589824}},
      '{32'sd0, 32'sd131073, 1'b1, '{32'sd65536, 32'sd131072, 32'sd589824}},
      '{32'sh7fffffff, 32'sh7fffffff, 1'b0, none},
      '{32'sh80000000, 32'sh80000000, 1'b0, none},
      '{32'sd32768, 32'sd0, 1'b0, none},
      '{-32'sd43690, 32'sd21845, 1'b0, none},
      '{32'sd21845, -32'sd43690, 1'b0, none},
      '{32'sd1, -32'sd1, 1'b0, none},
      '{-32'sd65536, 32'sd131072, 1'b0, none},
      '{32'sd65536, -32'sd131072, 1'b0, none},
      '{32'sd65535, 32'sh80000000, 1'b0, none},
      '{-32'sd65536, 32'sh7fffffff, 1'b0, none},
      '{-32'sd10923, 32'sd98303, 1'b0, none}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (dir_rows[i]) begin
      if (i == 2)
        load_config(32'd65536, 32'd393216, 32'd393216, 32'd393216,
                    32'd65536, 32'd131072, 32'd196608);
      send_word(dir_rows[i].err, dir_rows[i].rate, dir_rows[i].typed, dir_rows[i].gains);
    end

    // Random phases, extremes in the first two
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 3);
      case (p)
        0: load_config(32'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 32'h80000000, 32'h00000000);
        1: load_config(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 32'h7fffffff, 32'hffffffff);
        default: begin
          pick = $urandom_range(0, 2);
          sp = (pick == 0) ? $urandom_range(1, 1000) :
               (pick == 1) ? $urandom_range(16384, 1 << 20) : $urandom_range(1, 32'h7fffffff);
          load_config(DATA_W'(sp), rand_range_word($urandom_range(0, 2)),
                      rand_range_word($urandom_range(0, 2)),
                      rand_range_word($urandom_range(0, 2)), $urandom(), $urandom(),
                      $urandom());
        end
      endcase
      sp = longint'(span_r);
      for (int n = 0; n < RAND_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // inside the universe, but for a rate one past its upper edge
          e = longint'($urandom_range(0, 32'(2 * sp))) - sp;
          r = (longint'($urandom_range(0, 32'(2 * sp))) - sp) * 2 + $urandom_range(0, 1);
        end else if (pick < 80) begin
          // on or next to segment edges
          e = (sp * (int'($urandom_range(0, 12)) - 6)) / 6 + (int'($urandom_range(0, 2)) - 1);
          r = (sp * (int'($urandom_range(0, 12)) - 6)) / 3 + (int'($urandom_range(0, 2)) - 1);
        end else begin
          e = longint'($signed($urandom()));
          r = longint'($signed($urandom()));
        end
        send_word(DATA_W'(clamp32(e)), DATA_W'(clamp32(r)), 1'b0, none);
      end
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_gains.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

### fuzzy_pid_gain_tuner.f
rtl/fpgt_pkg.sv
rtl/fpgt_div.sv
rtl/fpgt_dp.sv
rtl/fpgt_ctrl.sv
rtl/fuzzy_pid_gain_tuner.sv
tb/tb_top.sv
